[sv/r2e_pkg.sv]
// constants, arctangent table and output rounding for the euler angle block
// no dependencies
package r2e_pkg;

    localparam int M_W           = 18;   // matrix entry, Q1.16 signed
    localparam int A_W           = 19;   // output angle, Q2.16 signed
    localparam int LIM_W         = 17;   // near-zero limit, Q1.16 unsigned
    localparam int VEC_W         = 38;   // atan2 vector datapath, Q30
    localparam int SC_W          = 34;   // sin/cos datapath, Q30
    localparam int Z_W           = 28;   // internal angle, Q24 radians
    localparam int DEF_CORDIC_STAGES = 16;

    localparam logic signed [Z_W-1:0]  PI_Q24      = 28'sd52707179;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [SC_W-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [A_W:0]    OUT_MAX     = 20'sd205887;

    typedef struct packed {
        logic signed [M_W-1:0] m02;
        logic signed [M_W-1:0] m10;
        logic signed [M_W-1:0] m11;
        logic signed [M_W-1:0] m12;
        logic signed [M_W-1:0] m20;
        logic signed [M_W-1:0] m21;
        logic signed [M_W-1:0] m22;
    } t_mat;

    // round(atan(2^-k) * 2^24)
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] k);
        logic signed [Z_W-1:0] v;
        case (k)
            5'd0:  v = 28'sd13176795;
            5'd1:  v = 28'sd7778716;
            5'd2:  v = 28'sd4110060;
            5'd3:  v = 28'sd2086331;
            5'd4:  v = 28'sd1047214;
            5'd5:  v = 28'sd524117;
            5'd6:  v = 28'sd262123;
            5'd7:  v = 28'sd131069;
            5'd8:  v = 28'sd65536;
            5'd9:  v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            5'd24: v = 28'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q24 to Q16 with round half up, then clamp to +-pi
    function automatic logic signed [A_W-1:0] angle_out(input logic signed [Z_W-1:0] z);
        logic signed [Z_W:0] r;
        r = ((Z_W+1)'(z) + (Z_W+1)'(128)) >>> 8;
        if (r > (Z_W+1)'(OUT_MAX)) begin
            r = (Z_W+1)'(OUT_MAX);
        end else if (r < -(Z_W+1)'(OUT_MAX)) begin
            r = -(Z_W+1)'(OUT_MAX);
        end
        return A_W'(r);
    endfunction

endpackage

[sv/r2e_if.sv]
// valid/ready channels for matrix entries in and euler angles out
// depends on r2e_pkg
interface r2e_in_if import r2e_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [M_W-1:0] m02;
    logic signed [M_W-1:0] m10;
    logic signed [M_W-1:0] m11;
    logic signed [M_W-1:0] m12;
    logic signed [M_W-1:0] m20;
    logic signed [M_W-1:0] m21;
    logic signed [M_W-1:0] m22;

    modport source (output valid, m02, m10, m11, m12, m20, m21, m22, input ready);
    modport sink   (input valid, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface r2e_out_if import r2e_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [A_W-1:0] angle_x;
    logic signed [A_W-1:0] angle_y;
    logic signed [A_W-1:0] angle_z;

    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

[sv/r2e_atan2.sv]
// pipelined vectoring cordic: atan2(y, x) in Q24
// depends on r2e_pkg
module r2e_atan2 import r2e_pkg::*; #(
    parameter int STAGES = DEF_CORDIC_STAGES,
    parameter int W      = VEC_W
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_x,
    input  logic signed [W-1:0]   i_y,
    output logic signed [Z_W-1:0] o_z
);

    logic signed [W-1:0]   r_x    [0:STAGES];
    logic signed [W-1:0]   r_y    [0:STAGES];
    logic signed [Z_W-1:0] r_z    [0:STAGES];
    logic                  r_zero [0:STAGES];

    // left half plane: flip the vector and start from +-pi
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? PI_Q24 : -PI_Q24;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q24(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q24(5'(i));
                end
            end
        end
    end

    assign o_z = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

[sv/r2e_sincos.sv]
// pipelined rotation cordic: sin and cos of a Q24 angle in Q30
// depends on r2e_pkg
module r2e_sincos import r2e_pkg::*; #(
    parameter int STAGES = DEF_CORDIC_STAGES,
    parameter int W      = SC_W
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [Z_W-1:0] i_z,
    output logic signed [W-1:0]   o_cos,
    output logic signed [W-1:0]   o_sin
);

    logic signed [W-1:0]   r_x   [0:STAGES];
    logic signed [W-1:0]   r_y   [0:STAGES];
    logic signed [Z_W-1:0] r_z   [0:STAGES];
    logic                  r_neg [0:STAGES];
    logic signed [W-1:0]   r_cos;
    logic signed [W-1:0]   r_sin;

    // fold into [-pi/2, pi/2], negate the result later
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= W'(GAIN_Q30);
            r_y[0] <= '0;
            if (i_z > HALF_PI_Q24) begin
                r_z[0]   <= i_z - PI_Q24;
                r_neg[0] <= 1'b1;
            end else if (i_z < -HALF_PI_Q24) begin
                r_z[0]   <= i_z + PI_Q24;
                r_neg[0] <= 1'b1;
            end else begin
                r_z[0]   <= i_z;
                r_neg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q24(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q24(5'(i));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];
            r_sin <= r_neg[STAGES] ? -r_y[STAGES] : r_y[STAGES];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[sv/rotation_matrix_to_xyz_euler.sv]
// rotation matrix to x-y-z euler angles, fully pipelined
// depends on r2e_pkg, r2e_if, r2e_atan2, r2e_sincos
//
//  port     | dir | contents
//  ---------+-----+--------------------------------------------
//  i_in     | in  | m02 m10 m11 m12 m20 m21 m22, Q1.16
//  o_out    | out | angle_x angle_y angle_z, Q2.16 radians
//  i_cfg_*  | in  | near_zero_limit write, Q1.16, reset 1 LSB
//
// one transaction per cycle while the output is not stalled; data passes the
// phi atan2, the sin/cos cordic, two multiply/sum stages and the theta/psi atan2
// reset clears the valid bits and sets the limit to one LSB
// a stalled output freezes every stage; no transaction is lost or repeated
module rotation_matrix_to_xyz_euler import r2e_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    r2e_in_if.sink           i_in,
    r2e_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_wdata
);

    localparam int LAT_A = CORDIC_STAGES + 1;
    localparam int LAT_S = CORDIC_STAGES + 2;
    localparam int D_M   = LAT_A + LAT_S;
    localparam int D_P   = LAT_S + 2 + LAT_A;
    localparam int TOT   = 2 * LAT_A + LAT_S + 4;
    localparam int P_W   = SC_W + M_W;

    logic [LIM_W-1:0]       r_limit;
    logic [TOT-1:0]         r_vld;
    logic                   en;

    t_mat                   n_mat;
    t_mat                   r_mat;
    t_mat                   r_mat_dly [0:D_M-1];
    logic signed [VEC_W-1:0] r_phi_x;
    logic signed [VEC_W-1:0] r_phi_y;
    logic [M_W-1:0]         abs12;
    logic [M_W-1:0]         abs22;
    logic                   near_zero;

    logic signed [Z_W-1:0]  phi_z;
    logic signed [Z_W-1:0]  r_phi_dly [0:D_P-1];
    logic signed [SC_W-1:0] sc_cos;
    logic signed [SC_W-1:0] sc_sin;

    logic signed [P_W-1:0]  r_c22, r_s12, r_c10, r_s20, r_c11, r_s21;
    logic signed [M_W-1:0]  r_m02_m1;
    logic signed [P_W:0]    sum_tx, sum_py, sum_px;
    logic signed [VEC_W-1:0] r_tx, r_ty, r_px, r_py;

    logic signed [Z_W-1:0]  theta_z;
    logic signed [Z_W-1:0]  psi_z;
    logic signed [A_W-1:0]  r_ax, r_ay, r_az;

    assign en         = !r_vld[TOT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_W'(1);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-2:0], i_in.valid};
        end
    end

    always_comb begin
        n_mat.m02 = i_in.m02;
        n_mat.m10 = i_in.m10;
        n_mat.m11 = i_in.m11;
        n_mat.m12 = i_in.m12;
        n_mat.m20 = i_in.m20;
        n_mat.m21 = i_in.m21;
        n_mat.m22 = i_in.m22;
        abs12     = i_in.m12[M_W-1] ? M_W'(-i_in.m12) : M_W'(i_in.m12);
        abs22     = i_in.m22[M_W-1] ? M_W'(-i_in.m22) : M_W'(i_in.m22);
        near_zero = (abs12 < {1'b0, r_limit}) && (abs22 < {1'b0, r_limit});
    end

    // near zero feeds a null vector, which the atan2 maps to zero
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mat <= n_mat;
            if (near_zero) begin
                r_phi_x <= '0;
                r_phi_y <= '0;
            end else begin
                r_phi_x <= VEC_W'(i_in.m22) <<< 14;
                r_phi_y <= -(VEC_W'(i_in.m12) <<< 14);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mat_dly[0] <= r_mat;
            for (int k = 1; k < D_M; k++) begin
                r_mat_dly[k] <= r_mat_dly[k-1];
            end
            r_phi_dly[0] <= phi_z;
            for (int k = 1; k < D_P; k++) begin
                r_phi_dly[k] <= r_phi_dly[k-1];
            end
        end
    end

    r2e_atan2 #(.STAGES(CORDIC_STAGES), .W(VEC_W)) u_atan_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_phi_x),
        .i_y   (r_phi_y),
        .o_z   (phi_z)
    );

    r2e_sincos #(.STAGES(CORDIC_STAGES), .W(SC_W)) u_sincos (
        .i_clk (i_clk),
        .i_en  (en),
        .i_z   (phi_z),
        .o_cos (sc_cos),
        .o_sin (sc_sin)
    );

    // products of cos/sin with rows 1 and 2, exact at Q46
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c22    <= sc_cos * r_mat_dly[D_M-1].m22;
            r_s12    <= sc_sin * r_mat_dly[D_M-1].m12;
            r_c10    <= sc_cos * r_mat_dly[D_M-1].m10;
            r_s20    <= sc_sin * r_mat_dly[D_M-1].m20;
            r_c11    <= sc_cos * r_mat_dly[D_M-1].m11;
            r_s21    <= sc_sin * r_mat_dly[D_M-1].m21;
            r_m02_m1 <= r_mat_dly[D_M-1].m02;
        end
    end

    always_comb begin
        sum_tx = (P_W+1)'(r_c22) - (P_W+1)'(r_s12);
        sum_py = (P_W+1)'(r_c10) + (P_W+1)'(r_s20);
        sum_px = (P_W+1)'(r_c11) + (P_W+1)'(r_s21);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx <= VEC_W'(sum_tx >>> 16);
            r_ty <= VEC_W'(r_m02_m1) <<< 14;
            r_py <= VEC_W'(sum_py >>> 16);
            r_px <= VEC_W'(sum_px >>> 16);
        end
    end

    r2e_atan2 #(.STAGES(CORDIC_STAGES), .W(VEC_W)) u_atan_theta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_tx),
        .i_y   (r_ty),
        .o_z   (theta_z)
    );

    r2e_atan2 #(.STAGES(CORDIC_STAGES), .W(VEC_W)) u_atan_psi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_px),
        .i_y   (r_py),
        .o_z   (psi_z)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= angle_out(r_phi_dly[D_P-1]);
            r_ay <= angle_out(theta_z);
            r_az <= angle_out(psi_z);
        end
    end

    assign o_out.valid   = r_vld[TOT-1];
    assign o_out.angle_x = r_ax;
    assign o_out.angle_y = r_ay;
    assign o_out.angle_z = r_az;

`ifndef SYNTHESIS
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_clamp_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.angle_x <= A_W'(OUT_MAX)) && (o_out.angle_x >= -A_W'(OUT_MAX)))
        else $error("angle_x out of range");

    a_limit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_cfg_we) |-> $stable(r_limit))
        else $error("limit changed without a write");
`endif

endmodule
